[rtl/core/gdd_pkg.sv]
// Gregorian day difference: shared widths, constants, payload structs and
// calendar lookup functions. No dependencies.
`default_nettype none

package gdd_pkg;

    localparam int MAX_YEAR = 9999;

    localparam int DAY_W    = 5;
    localparam int MONTH_W  = 4;
    localparam int YEAR_W   = 14;
    localparam int DIFF_W   = 23;
    localparam int ORD_W    = 9;   // ordinal within a year, up to 366
    localparam int LEAP_W   = 12;  // leap years before a year, up to YEAR range / 4
    localparam int DAYNUM_W = 23;  // day number, up to about 3.65e6
    localparam int WIDE_W   = DAYNUM_W + 1;

    // register stages inside one date unit
    localparam int DATE_STAGES = 3;

    // floor(x / 100) = (x * DIV100_MUL) >> DIV100_SHIFT, exact for x < 43690
    localparam int DIV100_MUL   = 5243;
    localparam int DIV100_SHIFT = 19;
    localparam int MUL_W        = 13;
    localparam int PROD_W       = YEAR_W + MUL_W;
    localparam int QUOT_W       = PROD_W - DIV100_SHIFT;

    localparam int YEAR_CMP_W   = 17;
    localparam int DAYS_COMMON  = 365;
    localparam int CENTURY      = 100;
    localparam int MONTHS       = 12;

    localparam int DIFF_MAX = 2 ** (DIFF_W - 1) - 1;
    localparam int DIFF_MIN = -(2 ** (DIFF_W - 1));

    typedef struct packed {
        logic [DAY_W-1:0]   first_day;
        logic [MONTH_W-1:0] first_month;
        logic [YEAR_W-1:0]  first_year;
        logic [DAY_W-1:0]   second_day;
        logic [MONTH_W-1:0] second_month;
        logic [YEAR_W-1:0]  second_year;
    } req_t;

    typedef struct packed {
        logic signed [DIFF_W-1:0] day_difference;
        logic                     bad_date;
    } rsp_t;

    typedef struct packed {
        logic [DAY_W-1:0]   day;
        logic [MONTH_W-1:0] month;
        logic [YEAR_W-1:0]  year;
    } date_in_t;

    typedef struct packed {
        logic                ok;
        logic [DAYNUM_W-1:0] day_num;
        logic [ORD_W-1:0]    ordinal;
    } date_info_t;

    // Length of a month; zero for a month code outside 1..12.
    function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] month,
                                                   input logic leap);
        logic [DAY_W-1:0] len;
        case (month) inside
            4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
            4'd4, 4'd6, 4'd9, 4'd11:                    len = 5'd30;
            4'd2:                                       len = leap ? 5'd29 : 5'd28;
            default:                                    len = '0;
        endcase
        return len;
    endfunction

    // Days in the months of the year before the given month.
    function automatic logic [ORD_W-1:0] days_before_month(input logic [MONTH_W-1:0] month,
                                                           input logic leap);
        logic [ORD_W-1:0] base;
        logic [ORD_W-1:0] adj;
        adj = (leap && month > 4'd2) ? ORD_W'(1) : ORD_W'(0);
        case (month)
            4'd1:    base = 9'd0;
            4'd2:    base = 9'd31;
            4'd3:    base = 9'd59;
            4'd4:    base = 9'd90;
            4'd5:    base = 9'd120;
            4'd6:    base = 9'd151;
            4'd7:    base = 9'd181;
            4'd8:    base = 9'd212;
            4'd9:    base = 9'd243;
            4'd10:   base = 9'd273;
            4'd11:   base = 9'd304;
            4'd12:   base = 9'd334;
            default: base = 9'd0;
        endcase
        return base + adj;
    endfunction

endpackage

`default_nettype wire

[rtl/core/gdd_date_unit.sv]
// Three-stage date evaluator: range checks and century division, leap and
// ordinal, then the closed-form day number. Depends on gdd_pkg.
`default_nettype none

module gdd_date_unit (
    input  wire logic                clk,
    input  wire gdd_pkg::date_in_t   date,
    output gdd_pkg::date_info_t      info
);

    // Stage 1: range checks, divide year and year-1 by one hundred
    logic [gdd_pkg::YEAR_W-1:0]  p_cur;
    logic                        range_ok_next;
    logic [gdd_pkg::PROD_W-1:0]  qy_prod_next;
    logic [gdd_pkg::PROD_W-1:0]  qp_prod_next;

    logic [gdd_pkg::DAY_W-1:0]   s1_day_reg;
    logic [gdd_pkg::MONTH_W-1:0] s1_month_reg;
    logic [gdd_pkg::YEAR_W-1:0]  s1_year_reg;
    logic                        s1_range_ok_reg;
    logic [gdd_pkg::PROD_W-1:0]  s1_qy_prod_reg;
    logic [gdd_pkg::PROD_W-1:0]  s1_qp_prod_reg;

    assign p_cur = date.year - gdd_pkg::YEAR_W'(1);

    assign range_ok_next = (date.year != '0)
        && ({{(gdd_pkg::YEAR_CMP_W - gdd_pkg::YEAR_W){1'b0}}, date.year}
            <= gdd_pkg::YEAR_CMP_W'(gdd_pkg::MAX_YEAR))
        && (date.month != '0)
        && (date.month <= gdd_pkg::MONTH_W'(gdd_pkg::MONTHS));

    assign qy_prod_next = gdd_pkg::PROD_W'(date.year)
                        * gdd_pkg::PROD_W'(gdd_pkg::DIV100_MUL);
    assign qp_prod_next = gdd_pkg::PROD_W'(p_cur)
                        * gdd_pkg::PROD_W'(gdd_pkg::DIV100_MUL);

    always_ff @(posedge clk)
    begin
        s1_day_reg      <= date.day;
        s1_month_reg    <= date.month;
        s1_year_reg     <= date.year;
        s1_range_ok_reg <= range_ok_next;
        s1_qy_prod_reg  <= qy_prod_next;
        s1_qp_prod_reg  <= qp_prod_next;
    end

    // Stage 2: leap rule, day check, ordinal, leap count before the year
    logic [gdd_pkg::QUOT_W-1:0]  qy;
    logic [gdd_pkg::QUOT_W-1:0]  qp;
    logic [gdd_pkg::YEAR_W-1:0]  century_part;
    logic [gdd_pkg::YEAR_W-1:0]  p_s1;
    logic                        leap;
    logic                        ok_next;
    logic [gdd_pkg::ORD_W-1:0]   ord_next;
    logic [gdd_pkg::LEAP_W-1:0]  leaps_next;

    logic                        s2_ok_reg;
    logic [gdd_pkg::ORD_W-1:0]   s2_ord_reg;
    logic [gdd_pkg::YEAR_W-1:0]  s2_p_reg;
    logic [gdd_pkg::LEAP_W-1:0]  s2_leaps_reg;

    assign qy = s1_qy_prod_reg[gdd_pkg::PROD_W-1:gdd_pkg::DIV100_SHIFT];
    assign qp = s1_qp_prod_reg[gdd_pkg::PROD_W-1:gdd_pkg::DIV100_SHIFT];
    assign p_s1 = s1_year_reg - gdd_pkg::YEAR_W'(1);
    assign century_part = gdd_pkg::YEAR_W'(qy) * gdd_pkg::YEAR_W'(gdd_pkg::CENTURY);

    // divisible by four, and either not a century or a century year divisible by 400
    assign leap = (s1_year_reg[1:0] == 2'b00)
               && ((century_part != s1_year_reg) || (qy[1:0] == 2'b00));

    assign ok_next = s1_range_ok_reg && (s1_day_reg != '0)
                  && (s1_day_reg <= gdd_pkg::month_len(s1_month_reg, leap));

    assign ord_next = gdd_pkg::ORD_W'(s1_day_reg)
                    + gdd_pkg::days_before_month(s1_month_reg, leap);

    assign leaps_next = gdd_pkg::LEAP_W'(p_s1 >> 2) - gdd_pkg::LEAP_W'(qp)
                      + gdd_pkg::LEAP_W'(qp >> 2);

    always_ff @(posedge clk)
    begin
        s2_ok_reg    <= ok_next;
        s2_ord_reg   <= ord_next;
        s2_p_reg     <= p_s1;
        s2_leaps_reg <= leaps_next;
    end

    // Stage 3: days before the year are 365 per year plus one per leap year, plus the ordinal
    gdd_pkg::date_info_t info_next;
    gdd_pkg::date_info_t info_reg;

    always_comb
    begin
        info_next.ok      = s2_ok_reg;
        info_next.ordinal = s2_ord_reg;
        info_next.day_num = gdd_pkg::DAYNUM_W'(s2_p_reg)
                            * gdd_pkg::DAYNUM_W'(gdd_pkg::DAYS_COMMON)
                          + gdd_pkg::DAYNUM_W'(s2_leaps_reg)
                          + gdd_pkg::DAYNUM_W'(s2_ord_reg);
    end

    always_ff @(posedge clk)
    begin
        info_reg <= info_next;
    end

    assign info = info_reg;

endmodule

`default_nettype wire

[rtl/core/gdd_diff_stage.sv]
// Final stage: subtract day numbers (ordinals within one year), saturate, zero on a bad date, and
// register the result strobe. Depends on gdd_pkg.
`default_nettype none

module gdd_diff_stage (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                valid,
    input  wire logic                same_year,
    input  wire gdd_pkg::date_info_t info_a,
    input  wire gdd_pkg::date_info_t info_b,
    output logic                     done,
    output gdd_pkg::rsp_t            rsp
);

    logic signed [gdd_pkg::WIDE_W-1:0] wide_diff;
    gdd_pkg::rsp_t                     rsp_next;
    gdd_pkg::rsp_t                     rsp_reg;
    logic                              done_reg;

    always_comb
    begin
        if (same_year)
            wide_diff = $signed(gdd_pkg::WIDE_W'(info_b.ordinal))
                      - $signed(gdd_pkg::WIDE_W'(info_a.ordinal));
        else
            wide_diff = $signed(gdd_pkg::WIDE_W'(info_b.day_num))
                      - $signed(gdd_pkg::WIDE_W'(info_a.day_num));

        rsp_next.bad_date = !(info_a.ok && info_b.ok);
        if (rsp_next.bad_date)
            rsp_next.day_difference = '0;
        else if (wide_diff > gdd_pkg::WIDE_W'(gdd_pkg::DIFF_MAX))
            rsp_next.day_difference = gdd_pkg::DIFF_W'(gdd_pkg::DIFF_MAX);
        else if (wide_diff < $signed(gdd_pkg::WIDE_W'(gdd_pkg::DIFF_MIN)))
            rsp_next.day_difference = gdd_pkg::DIFF_W'(gdd_pkg::DIFF_MIN);
        else
            rsp_next.day_difference = wide_diff[gdd_pkg::DIFF_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            done_reg <= 1'b0;
        else
            done_reg <= valid;
    end

    always_ff @(posedge clk)
    begin
        rsp_reg <= rsp_next;
    end

    assign done = done_reg;
    assign rsp  = rsp_reg;

endmodule

`default_nettype wire

[rtl/core/gregorian_day_difference.sv]
// Top level of the Gregorian day difference block: two date units, the
// difference stage and the valid pipeline. Depends on gdd_pkg,
// gdd_date_unit and gdd_diff_stage.
`default_nettype none

// Returns the signed number of days from the first date of a request to the
// second (second day number minus first). A request is taken at every clock
// edge where start is high; busy is never raised, so one request per cycle
// is sustained. Each result appears on rsp for exactly one cycle with done
// high, after its request passes three date stages (range check and
// divide by one hundred, leap rule and ordinal, multiply by 365 for the day
// number) and one subtract/saturate stage. Results come out in request
// order and cannot be held off. A month outside 1..12, a day of zero or past
// the month's end (February 29 only in leap years), or a year of zero or
// above MAX_YEAR sets bad_date and forces day_difference to zero. Dates in
// the same year return the difference of their ordinals.
module gregorian_day_difference (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          start,
    output logic               busy,
    input  wire gdd_pkg::req_t req,
    output logic               done,
    output gdd_pkg::rsp_t      rsp
);

    logic                      accept;
    gdd_pkg::date_in_t         date_a;
    gdd_pkg::date_in_t         date_b;
    gdd_pkg::date_info_t       info_a;
    gdd_pkg::date_info_t       info_b;

    logic [gdd_pkg::DATE_STAGES-1:0] valid_reg;
    logic [gdd_pkg::DATE_STAGES-1:0] valid_next;
    logic [gdd_pkg::DATE_STAGES-1:0] same_reg;
    logic [gdd_pkg::DATE_STAGES-1:0] same_next;

    // Pipeline never stalls, so requests are always welcome
    assign busy   = 1'b0;
    assign accept = start && !busy;

    assign date_a.day   = req.first_day;
    assign date_a.month = req.first_month;
    assign date_a.year  = req.first_year;
    assign date_b.day   = req.second_day;
    assign date_b.month = req.second_month;
    assign date_b.year  = req.second_year;

    gdd_date_unit u_date_a (
        .clk  (clk),
        .date (date_a),
        .info (info_a)
    );

    gdd_date_unit u_date_b (
        .clk  (clk),
        .date (date_b),
        .info (info_b)
    );

    // Advance valid and the same-year mark alongside the date stages
    assign valid_next = {valid_reg[gdd_pkg::DATE_STAGES-2:0], accept};
    assign same_next  = {same_reg[gdd_pkg::DATE_STAGES-2:0],
                         (req.first_year == req.second_year)};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= '0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        same_reg <= same_next;
    end

    gdd_diff_stage u_diff (
        .clk       (clk),
        .rst_n     (rst_n),
        .valid     (valid_reg[gdd_pkg::DATE_STAGES-1]),
        .same_year (same_reg[gdd_pkg::DATE_STAGES-1]),
        .info_a    (info_a),
        .info_b    (info_b),
        .done      (done),
        .rsp       (rsp)
    );

    // Every accepted request yields a result after the date and difference stages
    a_req_to_done: assert property (@(posedge clk) disable iff (!rst_n)
        accept |-> ##4 done)
        else $error("accepted request produced no result");

    // No result without a matching earlier request
    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        !accept |-> ##4 !done)
        else $error("result without a request");

    // A flagged result carries a zero difference
    a_bad_is_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && rsp.bad_date) |-> (rsp.day_difference == '0))
        else $error("bad date with nonzero difference");

endmodule

`default_nettype wire
